>>> design/psaa_pkg.sv
// ----------------------------------------------------------------------------
// psaa_pkg
// shared constants and types for the pixel sample average accumulator
// ----------------------------------------------------------------------------
package psaa_pkg;

    // frame geometry
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int DEPTH        = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS    = $clog2(DEPTH);
    localparam int POS_BITS     = 8;
    localparam int DIM_BITS     = 9;

    // arithmetic widths
    localparam int CHANNEL_BITS = 16;
    localparam int COUNT_BITS   = 16;
    localparam int SUM_BITS     = CHANNEL_BITS + COUNT_BITS;
    localparam int DIV_CNT_BITS = $clog2(CHANNEL_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // register indexes
    localparam int REG_IDX_BITS = 1;
    localparam logic [REG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [REG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    // one pixel entry of the store
    typedef struct packed {
        logic [SUM_BITS-1:0]   red_sum;
        logic [SUM_BITS-1:0]   green_sum;
        logic [SUM_BITS-1:0]   blue_sum;
        logic [COUNT_BITS-1:0] count;
    } pixel_entry_t;

    // write request into the store
    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        pixel_entry_t         data;
    } mem_wr_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

>>> design/pixel_sample_average_accumulator_top.sv
// ----------------------------------------------------------------------------
// pixel_sample_average_accumulator_top
// per-pixel running average store for progressive rendering
// ----------------------------------------------------------------------------
// an add request gives its result after the read-modify-write, the division
// and the result state; an out of range add gives it in the next cycle; a
// clear gives none and holds busy while it sweeps width * height entries.
// one request at a time; an in-range add runs through the 16-step divider.
// the receiver cannot stall, a result is shown for exactly one cycle. after
// reset the whole store is swept to zero, one entry per cycle, busy high meanwhile; registers are writable then
module pixel_sample_average_accumulator_top
    import psaa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    // configuration write port
    input  logic                    wr_en,
    input  logic [REG_IDX_BITS-1:0] wr_index,
    input  logic [DIM_BITS-1:0]     wr_data,

    // request side
    input  logic                    start,
    output logic                    busy,
    input  logic                    op,
    input  logic [POS_BITS-1:0]     pos_x,
    input  logic [POS_BITS-1:0]     pos_y,
    input  logic [CHANNEL_BITS-1:0] red,
    input  logic [CHANNEL_BITS-1:0] green,
    input  logic [CHANNEL_BITS-1:0] blue,

    // result side
    output logic                    done,
    output logic [CHANNEL_BITS-1:0] avg_red,
    output logic [CHANNEL_BITS-1:0] avg_green,
    output logic [CHANNEL_BITS-1:0] avg_blue,
    output logic [COUNT_BITS-1:0]   sample_total,
    output logic                    out_of_range,
    output logic                    count_saturated
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_BITS-1:0] frame_width_reg;
    logic [DIM_BITS-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_BITS'(MAX_WIDTH);
            frame_height_reg <= DIM_BITS'(MAX_HEIGHT);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= wr_data;
                REG_FRAME_HEIGHT: frame_height_reg <= wr_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // effective frame size: zero acts as one, clamped to the store size
    // ------------------------------------------------------------------
    logic [DIM_BITS-1:0]          width_eff;
    logic [DIM_BITS-1:0]          height_eff;
    logic                         pos_outside;
    logic [POS_BITS+DIM_BITS-1:0] addr_full;
    logic [2*DIM_BITS-1:0]        frame_area;
    logic [2*DIM_BITS-1:0]        frame_last;

    always_comb
    begin
        if (frame_width_reg == '0)
            width_eff = DIM_BITS'(1);
        else if (frame_width_reg > DIM_BITS'(MAX_WIDTH))
            width_eff = DIM_BITS'(MAX_WIDTH);
        else
            width_eff = frame_width_reg;

        if (frame_height_reg == '0)
            height_eff = DIM_BITS'(1);
        else if (frame_height_reg > DIM_BITS'(MAX_HEIGHT))
            height_eff = DIM_BITS'(MAX_HEIGHT);
        else
            height_eff = frame_height_reg;

        pos_outside = ({1'b0, pos_x} >= width_eff) || ({1'b0, pos_y} >= height_eff);

        // row-major pixel address, in range whenever the position is inside
        addr_full = (POS_BITS+DIM_BITS)'(pos_y) * (POS_BITS+DIM_BITS)'(width_eff)
                  + (POS_BITS+DIM_BITS)'(pos_x);

        // clear sweeps the first width * height entries
        frame_area = (2*DIM_BITS)'(width_eff) * (2*DIM_BITS)'(height_eff);
        frame_last = frame_area - (2*DIM_BITS)'(1);
    end

    // ------------------------------------------------------------------
    // pixel store
    // ------------------------------------------------------------------
    mem_wr_t              mem_wr;
    logic                 mem_rd_en;
    logic [ADDR_BITS-1:0] mem_rd_addr;
    pixel_entry_t         mem_rd_data;

    psaa_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // one divider per channel, all sharing the pixel count as divisor
    // ------------------------------------------------------------------
    logic                    div_load;
    logic                    div_step;
    pixel_entry_t            entry_new;
    logic [CHANNEL_BITS-1:0] quo_red;
    logic [CHANNEL_BITS-1:0] quo_green;
    logic [CHANNEL_BITS-1:0] quo_blue;

    psaa_div u_div_red (
        .clk      (clk),
        .load     (div_load),
        .step     (div_step),
        .dividend (entry_new.red_sum),
        .divisor  (entry_new.count),
        .quotient (quo_red)
    );

    psaa_div u_div_green (
        .clk      (clk),
        .load     (div_load),
        .step     (div_step),
        .dividend (entry_new.green_sum),
        .divisor  (entry_new.count),
        .quotient (quo_green)
    );

    psaa_div u_div_blue (
        .clk      (clk),
        .load     (div_load),
        .step     (div_step),
        .dividend (entry_new.blue_sum),
        .divisor  (entry_new.count),
        .quotient (quo_blue)
    );

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    state_t                  state_reg,      state_next;
    logic [ADDR_BITS-1:0]    clr_addr_reg,   clr_addr_next;
    logic [ADDR_BITS-1:0]    clr_end_reg,    clr_end_next;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg,    div_cnt_next;
    logic                    done_reg,       done_next;

    // request and result payload
    logic [ADDR_BITS-1:0]    addr_reg,       addr_next;
    logic [CHANNEL_BITS-1:0] red_in_reg,     red_in_next;
    logic [CHANNEL_BITS-1:0] green_in_reg,   green_in_next;
    logic [CHANNEL_BITS-1:0] blue_in_reg,    blue_in_next;
    logic [COUNT_BITS-1:0]   count_hold_reg, count_hold_next;
    logic                    sat_hold_reg,   sat_hold_next;
    logic [CHANNEL_BITS-1:0] avg_red_reg,    avg_red_next;
    logic [CHANNEL_BITS-1:0] avg_green_reg,  avg_green_next;
    logic [CHANNEL_BITS-1:0] avg_blue_reg,   avg_blue_next;
    logic [COUNT_BITS-1:0]   total_reg,      total_next;
    logic                    oor_reg,        oor_next;
    logic                    sat_reg,        sat_next;

    logic accept;
    logic is_sat;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_end_next    = clr_end_reg;
        div_cnt_next    = div_cnt_reg;
        done_next       = 1'b0;
        addr_next       = addr_reg;
        red_in_next     = red_in_reg;
        green_in_next   = green_in_reg;
        blue_in_next    = blue_in_reg;
        count_hold_next = count_hold_reg;
        sat_hold_next   = sat_hold_reg;
        avg_red_next    = avg_red_reg;
        avg_green_next  = avg_green_reg;
        avg_blue_next   = avg_blue_reg;
        total_next      = total_reg;
        oor_next        = oor_reg;
        sat_next        = sat_reg;

        mem_wr      = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = addr_full[ADDR_BITS-1:0];
        div_load    = 1'b0;
        div_step    = 1'b0;

        // read-modify: saturated pixels keep their sums and count
        is_sat = (mem_rd_data.count == COUNT_MAX);
        if (is_sat)
        begin
            entry_new = mem_rd_data;
        end
        else
        begin
            entry_new.red_sum   = mem_rd_data.red_sum   + SUM_BITS'(red_in_reg);
            entry_new.green_sum = mem_rd_data.green_sum + SUM_BITS'(green_in_reg);
            entry_new.blue_sum  = mem_rd_data.blue_sum  + SUM_BITS'(blue_in_reg);
            entry_new.count     = mem_rd_data.count + COUNT_BITS'(1);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // zero one entry per cycle up to the end address
                mem_wr.en   = 1'b1;
                mem_wr.addr = clr_addr_reg;
                mem_wr.data = '0;
                clr_addr_next = clr_addr_reg + ADDR_BITS'(1);
                if (clr_addr_reg == clr_end_reg)
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_CLEAR)
                    begin
                        clr_addr_next = '0;
                        clr_end_next  = frame_last[ADDR_BITS-1:0];
                        state_next    = ST_CLEAR;
                    end
                    else if (pos_outside)
                    begin
                        // no store access, zero result next cycle
                        done_next      = 1'b1;
                        avg_red_next   = '0;
                        avg_green_next = '0;
                        avg_blue_next  = '0;
                        total_next     = '0;
                        oor_next       = 1'b1;
                        sat_next       = 1'b0;
                    end
                    else
                    begin
                        mem_rd_en     = 1'b1;
                        addr_next     = addr_full[ADDR_BITS-1:0];
                        red_in_next   = red;
                        green_in_next = green;
                        blue_in_next  = blue;
                        state_next    = ST_MODIFY;
                    end
                end
            end

            ST_MODIFY:
            begin
                // read data is valid here; write back and start the division
                mem_wr.en       = !is_sat;
                mem_wr.addr     = addr_reg;
                mem_wr.data     = entry_new;
                div_load        = 1'b1;
                count_hold_next = entry_new.count;
                sat_hold_next   = is_sat;
                div_cnt_next    = DIV_CNT_BITS'(CHANNEL_BITS - 1);
                state_next      = ST_DIV;
            end

            ST_DIV:
            begin
                div_step     = 1'b1;
                div_cnt_next = div_cnt_reg - DIV_CNT_BITS'(1);
                if (div_cnt_reg == '0)
                    state_next = ST_DONE;
            end

            ST_DONE:
            begin
                done_next      = 1'b1;
                avg_red_next   = quo_red;
                avg_green_next = quo_green;
                avg_blue_next  = quo_blue;
                total_next     = count_hold_reg;
                oor_next       = 1'b0;
                sat_next       = sat_hold_reg;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state; reset starts the full store sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            clr_end_reg  <= ADDR_BITS'(DEPTH - 1);
            div_cnt_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_end_reg  <= clr_end_next;
            div_cnt_reg  <= div_cnt_next;
            done_reg     <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        red_in_reg     <= red_in_next;
        green_in_reg   <= green_in_next;
        blue_in_reg    <= blue_in_next;
        count_hold_reg <= count_hold_next;
        sat_hold_reg   <= sat_hold_next;
        avg_red_reg    <= avg_red_next;
        avg_green_reg  <= avg_green_next;
        avg_blue_reg   <= avg_blue_next;
        total_reg      <= total_next;
        oor_reg        <= oor_next;
        sat_reg        <= sat_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign avg_red         = avg_red_reg;
    assign avg_green       = avg_green_reg;
    assign avg_blue        = avg_blue_reg;
    assign sample_total    = total_reg;
    assign out_of_range    = oor_reg;
    assign count_saturated = sat_reg;

endmodule

>>> design/psaa_mem.sv
// ----------------------------------------------------------------------------
// psaa_mem
// pixel store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module psaa_mem
    import psaa_pkg::*;
(
    input  logic                 clk,
    input  mem_wr_t              wr,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output pixel_entry_t         rd_data
);

    pixel_entry_t store_mem [0:DEPTH-1];
    pixel_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/psaa_div.sv
// ----------------------------------------------------------------------------
// psaa_div
// restoring divider, one quotient bit per step; quotient must fit CHANNEL_BITS
// ----------------------------------------------------------------------------
module psaa_div
    import psaa_pkg::*;
(
    input  logic                    clk,
    input  logic                    load,
    input  logic                    step,
    input  logic [SUM_BITS-1:0]     dividend,
    input  logic [COUNT_BITS-1:0]   divisor,
    output logic [CHANNEL_BITS-1:0] quotient
);

    logic [COUNT_BITS-1:0]   rem_reg;
    logic [COUNT_BITS-1:0]   rem_next;
    logic [CHANNEL_BITS-1:0] quo_reg;
    logic [CHANNEL_BITS-1:0] quo_next;
    logic [COUNT_BITS-1:0]   dvs_reg;
    logic [COUNT_BITS:0]     trial;
    logic [COUNT_BITS:0]     diff;
    logic                    fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[CHANNEL_BITS-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        quo_next = {quo_reg[CHANNEL_BITS-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            // high part is below the divisor, so the quotient fits
            rem_reg <= dividend[SUM_BITS-1 -: COUNT_BITS];
            quo_reg <= dividend[CHANNEL_BITS-1:0];
            dvs_reg <= divisor;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule

>>> design/psaa_checker.sv
// ----------------------------------------------------------------------------
// psaa_checker
// port-level checks for the pixel sample average accumulator
// ----------------------------------------------------------------------------
module psaa_checker
    import psaa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    op,
    input  logic                    done,
    input  logic [CHANNEL_BITS-1:0] avg_red,
    input  logic [CHANNEL_BITS-1:0] avg_green,
    input  logic [CHANNEL_BITS-1:0] avg_blue,
    input  logic [COUNT_BITS-1:0]   sample_total,
    input  logic                    out_of_range,
    input  logic                    count_saturated
);

    // a result only follows an accepted request or ongoing work
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start || busy))
        else $error("result without a request");

    // a clear request taken while idle raises busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_CLEAR) |=> busy)
        else $error("clear accepted but block not busy");

    // out of range results carry zero averages and count
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |-> (avg_red == '0 && avg_green == '0 &&
                                    avg_blue == '0 && sample_total == '0 &&
                                    !count_saturated))
        else $error("out of range result not zero");

    // an in-range result always has at least one sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !out_of_range) |-> (sample_total != '0))
        else $error("in-range result with zero count");

    // a dropped sample is only reported at the maximum count
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && count_saturated) |-> (sample_total == COUNT_MAX))
        else $error("saturation flagged below maximum count");

endmodule

bind pixel_sample_average_accumulator_top psaa_checker u_psaa_checker (.*);
